FILE: hdl/spq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// spq_pkg: shared types and constants of the sorted priority queue
// Operation codes, the control word broadcast to the cell chain and the
// capacity register layout.
// ---------------------------------------------------------------------------
package spq_pkg;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } spq_op_e;

  // control broadcast to every cell of the chain
  typedef struct packed {
    logic insert_en;
    logic remove_en;
  } spq_ctl_t;

  localparam int unsigned CfgW = 5;
  localparam logic [CfgW-1:0] CfgReset = 5'd16;

endpackage : spq_pkg
`default_nettype wire

FILE: hdl/sorted_priority_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// The result strobe done_o comes in the cycle after start is taken.
// Throughput: 1 command per cycle; busy stays low, since all cells compare
// against the new entry in parallel and shift in the same cycle.
// Reset: entry count 0, capacity_in_use 16; cell contents undefined.
// Results cannot be stalled by the receiver.
// ---------------------------------------------------------------------------
// sorted_priority_queue: bounded priority queue, descending priority
// Row of CAPACITY cells kept sorted; equal priorities leave in arrival order.
// ---------------------------------------------------------------------------
module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int unsigned CAPACITY      = 16,
  parameter int unsigned TAG_BITS      = 16,
  parameter int unsigned PRIORITY_BITS = 16,
  localparam int unsigned CntW         = $clog2(CAPACITY + 1)
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic                            operation_i,
  input  wire logic signed [PRIORITY_BITS-1:0] priority_req_i,
  input  wire logic [TAG_BITS-1:0]             task_tag_i,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [CfgW-1:0]                 cfg_data_i,
  output logic                                 done_o,
  output logic                                 accepted_o,
  output logic                                 head_valid_o,
  output logic [TAG_BITS-1:0]                  head_tag_o,
  output logic [PRIORITY_BITS-2:0]             head_priority_o,
  output logic [CntW-1:0]                      entry_count_o,
  output logic                                 queue_empty_o
);

  localparam int unsigned PriW = PRIORITY_BITS - 1;
  localparam int unsigned LimW = (CntW > CfgW) ? CntW : CfgW;

  logic [CfgW-1:0] cap_q;
  logic [CntW-1:0] count_q, count_d;
  logic            done_q, ok_q, ok_d;
  logic            take;
  logic            neg;
  logic [LimW-1:0] limit;
  logic            full;
  spq_ctl_t        ctl;
  logic [PriW-1:0] new_pri;

  logic            lt   [CAPACITY];
  logic [PriW-1:0] pri  [CAPACITY];
  logic [TAG_BITS-1:0] tag [CAPACITY];

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign take        = start && !busy;

  assign neg     = priority_req_i[PRIORITY_BITS-1];
  assign new_pri = priority_req_i[PriW-1:0];

  // capacity above the cell count acts as the cell count
  assign limit = (LimW'(cap_q) > LimW'(CAPACITY)) ? LimW'(CAPACITY) : LimW'(cap_q);
  assign full  = LimW'(count_q) >= limit;

  always_comb begin
    ctl     = '0;
    ok_d    = 1'b0;
    count_d = count_q;
    if (take) begin
      unique case (spq_op_e'(operation_i))
        OP_INSERT: begin
          if (!neg && !full) begin
            ctl.insert_en = 1'b1;
            ok_d          = 1'b1;
            count_d       = count_q + CntW'(1);
          end
        end
        OP_REMOVE: begin
          if (count_q != '0) begin
            ctl.remove_en = 1'b1;
            ok_d          = 1'b1;
            count_d       = count_q - CntW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic            prev_lt;
    logic [PriW-1:0] prev_pri, next_pri;
    logic [TAG_BITS-1:0] prev_tag, next_tag;

    if (i == 0) begin : g_first
      assign prev_lt  = 1'b0;
      assign prev_pri = new_pri;
      assign prev_tag = task_tag_i;
    end else begin : g_mid
      assign prev_lt  = lt[i-1];
      assign prev_pri = pri[i-1];
      assign prev_tag = tag[i-1];
    end

    // the last cell's content after a remove is beyond the count
    if (i == CAPACITY - 1) begin : g_last
      assign next_pri = new_pri;
      assign next_tag = task_tag_i;
    end else begin : g_inner
      assign next_pri = pri[i+1];
      assign next_tag = tag[i+1];
    end

    spq_cell #(
      .PRI_W(PriW),
      .TAG_W(TAG_BITS)
    ) u_cell (
      .clk_i     (clk_i),
      .ctl_i     (ctl),
      .valid_i   (count_q > CntW'(i)),
      .new_pri_i (new_pri),
      .new_tag_i (task_tag_i),
      .prev_lt_i (prev_lt),
      .prev_pri_i(prev_pri),
      .prev_tag_i(prev_tag),
      .next_pri_i(next_pri),
      .next_tag_i(next_tag),
      .lt_o      (lt[i]),
      .pri_o     (pri[i]),
      .tag_o     (tag[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= CfgReset;
      count_q <= '0;
      done_q  <= 1'b0;
      ok_q    <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
      count_q <= count_d;
      done_q  <= take;
      ok_q    <= ok_d;
    end
  end

  assign done_o          = done_q;
  assign accepted_o      = ok_q;
  assign head_valid_o    = count_q != '0;
  assign queue_empty_o   = count_q == '0;
  assign entry_count_o   = count_q;
  assign head_tag_o      = head_valid_o ? tag[0] : '0;
  assign head_priority_o = head_valid_o ? pri[0] : '0;

endmodule : sorted_priority_queue
`default_nettype wire

FILE: hdl/spq_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// spq_cell: one slot of the sorted chain
// Holds one entry. On insert it keeps, takes the new entry or takes its
// left neighbor; on remove it takes its right neighbor.
// ---------------------------------------------------------------------------
module spq_cell
  import spq_pkg::*;
#(
  parameter int unsigned PRI_W = 15,
  parameter int unsigned TAG_W = 16
) (
  input  wire logic             clk_i,
  input  wire spq_ctl_t         ctl_i,
  input  wire logic             valid_i,
  input  wire logic [PRI_W-1:0] new_pri_i,
  input  wire logic [TAG_W-1:0] new_tag_i,
  input  wire logic             prev_lt_i,
  input  wire logic [PRI_W-1:0] prev_pri_i,
  input  wire logic [TAG_W-1:0] prev_tag_i,
  input  wire logic [PRI_W-1:0] next_pri_i,
  input  wire logic [TAG_W-1:0] next_tag_i,
  output logic                  lt_o,
  output logic [PRI_W-1:0]      pri_o,
  output logic [TAG_W-1:0]      tag_o
);

  logic [PRI_W-1:0] pri_q, pri_d;
  logic [TAG_W-1:0] tag_q, tag_d;

  // new entry goes behind every held entry of equal or higher priority
  assign lt_o = !(valid_i && (pri_q >= new_pri_i));

  always_comb begin
    pri_d = pri_q;
    tag_d = tag_q;
    if (ctl_i.insert_en && lt_o) begin
      if (prev_lt_i) begin
        pri_d = prev_pri_i;
        tag_d = prev_tag_i;
      end else begin
        pri_d = new_pri_i;
        tag_d = new_tag_i;
      end
    end else if (ctl_i.remove_en) begin
      pri_d = next_pri_i;
      tag_d = next_tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pri_q <= pri_d;
    tag_q <= tag_d;
  end

  assign pri_o = pri_q;
  assign tag_o = tag_q;

endmodule : spq_cell
`default_nettype wire

FILE: hdl/spq_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// spq_checker: port-level checks of the sorted priority queue
// Result timing and consistency of the reported head and count.
// ---------------------------------------------------------------------------
module spq_checker #(
  parameter int unsigned CAPACITY      = 16,
  parameter int unsigned TAG_BITS      = 16,
  parameter int unsigned PRIORITY_BITS = 16,
  localparam int unsigned CntW         = $clog2(CAPACITY + 1)
) (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       start,
  input wire logic                       busy,
  input wire logic                       done_o,
  input wire logic                       head_valid_o,
  input wire logic [TAG_BITS-1:0]        head_tag_o,
  input wire logic [PRIORITY_BITS-2:0]   head_priority_o,
  input wire logic [CntW-1:0]            entry_count_o,
  input wire logic                       queue_empty_o
);

  // every transfer in yields exactly one result on the next cycle
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> done_o)
    else $error("missing result strobe after command transfer");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy))
    else $error("result strobe without a command");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((queue_empty_o == (entry_count_o == '0)) &&
                (head_valid_o != queue_empty_o)))
    else $error("empty flag, head flag and count disagree");

  a_empty_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && queue_empty_o) |-> ((head_tag_o == '0) && (head_priority_o == '0)))
    else $error("head fields not zero on empty queue");

endmodule : spq_checker

bind sorted_priority_queue spq_checker #(
  .CAPACITY     (CAPACITY),
  .TAG_BITS     (TAG_BITS),
  .PRIORITY_BITS(PRIORITY_BITS)
) u_spq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .done_o         (done_o),
  .head_valid_o   (head_valid_o),
  .head_tag_o     (head_tag_o),
  .head_priority_o(head_priority_o),
  .entry_count_o  (entry_count_o),
  .queue_empty_o  (queue_empty_o)
);
`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: self-checking bench for sorted_priority_queue
// Drives insert and remove commands through the start/busy handshake,
// predicts every head/count report with a sorted array model, and moves the
// capacity limit through zero, one, full, oversize and random settings.
// ---------------------------------------------------------------------------
module testbench;
  import spq_pkg::*;

  localparam int unsigned QDEPTH    = 16;
  localparam int unsigned TAG_W     = 16;
  localparam int unsigned PRI_W     = 16;
  localparam int unsigned RAND_CMDS = 1650;
  localparam int unsigned CALM_TAIL = 1400;  // no idling past this many
  localparam int unsigned LIMIT     = 200000;

  typedef struct packed {
    logic             accepted;
    logic             head_valid;
    logic [TAG_W-1:0] head_tag;
    logic [PRI_W-2:0] head_priority;
    logic [4:0]       entry_count;
    logic             queue_empty;
  } queue_report_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    start;
  logic                    busy;
  logic                    operation_i;
  logic signed [PRI_W-1:0] priority_req_i;
  logic [TAG_W-1:0]        task_tag_i;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [CfgW-1:0]         cfg_data_i;
  logic                    done_o;
  logic                    accepted_o;
  logic                    head_valid_o;
  logic [TAG_W-1:0]        head_tag_o;
  logic [PRI_W-2:0]        head_priority_o;
  logic [4:0]              entry_count_o;
  logic                    queue_empty_o;

  sorted_priority_queue #(
    .CAPACITY      (QDEPTH),
    .TAG_BITS      (TAG_W),
    .PRIORITY_BITS (PRI_W)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .operation_i     (operation_i),
    .priority_req_i  (priority_req_i),
    .task_tag_i      (task_tag_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .done_o          (done_o),
    .accepted_o      (accepted_o),
    .head_valid_o    (head_valid_o),
    .head_tag_o      (head_tag_o),
    .head_priority_o (head_priority_o),
    .entry_count_o   (entry_count_o),
    .queue_empty_o   (queue_empty_o)
  );

  // sorted model of the queue contents, head at slot 0
  logic [PRI_W-2:0] slot_pri [QDEPTH];
  logic [TAG_W-1:0] slot_tag [QDEPTH];
  int unsigned      held;
  logic [CfgW-1:0]  cap_model;

  queue_report_t pending_reports[$];
  queue_report_t want_report;
  queue_report_t got_report;

  int unsigned errors;
  int unsigned cycle_count;
  int unsigned random_sent;
  int unsigned n_commands, n_stored, n_served, n_full_rejects;
  int unsigned n_negative, n_empty_removes, max_held, n_cfg_writes;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d reports outstanding",
             cycle_count, pending_reports.size());
    $display("testbench: FAIL");
    $finish;
  end

  function automatic queue_report_t apply_queue_op(spq_op_e op,
                                                   logic signed [PRI_W-1:0] pri,
                                                   logic [TAG_W-1:0] tag);
    queue_report_t r;
    int unsigned   limit;
    int unsigned   pos;
    int            k;
    logic          ok;
    limit = (cap_model > QDEPTH) ? QDEPTH : cap_model;
    ok = 1'b0;
    n_commands++;
    if (op == OP_INSERT) begin
      if (pri[PRI_W-1]) begin
        n_negative++;
      end else if (held >= limit) begin
        n_full_rejects++;
      end else begin
        pos = 0;
        while (pos < held && slot_pri[pos] >= pri[PRI_W-2:0]) pos++;
        for (k = held; k > pos; k--) begin
          slot_pri[k] = slot_pri[k-1];
          slot_tag[k] = slot_tag[k-1];
        end
        slot_pri[pos] = pri[PRI_W-2:0];
        slot_tag[pos] = tag;
        held++;
        ok = 1'b1;
        n_stored++;
      end
    end else begin
      if (held == 0) begin
        n_empty_removes++;
      end else begin
        for (k = 0; k + 1 < held; k++) begin
          slot_pri[k] = slot_pri[k+1];
          slot_tag[k] = slot_tag[k+1];
        end
        held--;
        ok = 1'b1;
        n_served++;
      end
    end
    if (held > max_held) max_held = held;
    r.accepted      = ok;
    r.head_valid    = (held != 0);
    r.head_tag      = (held != 0) ? slot_tag[0] : '0;
    r.head_priority = (held != 0) ? slot_pri[0] : '0;
    r.entry_count   = held[4:0];
    r.queue_empty   = (held == 0);
    return r;
  endfunction

  // one process: check the report due now, then record this edge's transfers
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        got_report = '{accepted_o, head_valid_o, head_tag_o, head_priority_o,
                       entry_count_o, queue_empty_o};
        if (pending_reports.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: report with no command outstanding", $realtime);
        end else begin
          want_report = pending_reports.pop_front();
          if (got_report !== want_report) begin
            errors++;
            if (errors <= 10)
              $display({"%0t: mismatch acc %b/%b vld %b/%b tag %h/%h pri %0d/%0d",
                        " cnt %0d/%0d empty %b/%b (expected/actual)"}, $realtime,
                       want_report.accepted, got_report.accepted,
                       want_report.head_valid, got_report.head_valid,
                       want_report.head_tag, got_report.head_tag,
                       want_report.head_priority, got_report.head_priority,
                       want_report.entry_count, got_report.entry_count,
                       want_report.queue_empty, got_report.queue_empty);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        cap_model = cfg_data_i;
        n_cfg_writes++;
      end
      if (start && !busy)
        pending_reports.push_back(apply_queue_op(spq_op_e'(operation_i),
                                                 priority_req_i, task_tag_i));
    end
  end

  task automatic send_command(input spq_op_e op, input logic signed [PRI_W-1:0] pri,
                              input logic [TAG_W-1:0] tag);
    start          <= 1'b1;
    operation_i    <= op;
    priority_req_i <= pri;
    task_tag_i     <= tag;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic push_entry(input logic signed [PRI_W-1:0] pri,
                            input logic [TAG_W-1:0] tag);
    send_command(OP_INSERT, pri, tag);
  endtask

  // priority and tag are don't-care on a remove; keep them moving anyway
  task automatic pop_head();
    send_command(OP_REMOVE, PRI_W'($urandom), TAG_W'($urandom));
  endtask

  task automatic idle_gap(input int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [CfgW-1:0] value);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic signed [PRI_W-1:0] pick_priority();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 3) return {1'b1, 15'($urandom)};          // negative
    if (r < 8) return {1'b0, 15'($urandom)};          // full range
    return PRI_W'($urandom_range(0, 7));              // many ties
  endfunction

  task automatic test_directed();
    pop_head();                                   // remove while empty
    push_entry(16'sh7fff, 16'hffff);              // top priority
    push_entry(16'sh0000, 16'h0000);              // lowest priority
    push_entry(-16'sd1, 16'h1234);                // negative, rejected
    push_entry(16'sh8000, 16'h5678);              // most negative, rejected
    push_entry(16'sd100, 16'h00a1);               // three ties in arrival order
    push_entry(16'sd100, 16'h00b2);
    push_entry(16'sd100, 16'h00c3);
    push_entry(16'sd50, 16'h0050);
    repeat (7) pop_head();                        // last one hits empty
  endtask

  task automatic test_capacity();
    write_capacity(5'd1);
    push_entry(16'sd5, 16'h0001);
    push_entry(16'sd6, 16'h0002);                 // full at one entry
    pop_head();
    pop_head();
    write_capacity(5'd0);                         // zero capacity
    push_entry(16'sd10, 16'h0003);
    write_capacity(5'd31);                        // oversize acts as full depth
    repeat (QDEPTH + 1) push_entry(PRI_W'($urandom_range(0, 3)), TAG_W'($urandom));
    write_capacity(5'd3);                         // lowered below the count
    push_entry(16'sd20, 16'h0004);
    repeat (QDEPTH - 3) pop_head();
    push_entry(16'sd20, 16'h0005);                // still at the limit
    pop_head();
    push_entry(16'sd20, 16'h0006);
    write_capacity(5'd16);
    repeat (4) pop_head();
  endtask

  task automatic test_random();
    int unsigned     burst;
    int unsigned     insert_pct;
    logic            idle_on;
    logic [CfgW-1:0] cap;
    while (random_sent < RAND_CMDS) begin
      case ($urandom_range(0, 7))
        0:       cap = 5'd0;
        1:       cap = 5'd1;
        2:       cap = 5'd31;
        3:       cap = 5'd16;
        default: cap = 5'($urandom_range(0, 31));
      endcase
      write_capacity(cap);
      burst      = $urandom_range(30, 120);
      if (burst > RAND_CMDS - random_sent) burst = RAND_CMDS - random_sent;
      insert_pct = $urandom_range(25, 80);
      idle_on    = ($urandom_range(0, 3) != 0);
      repeat (burst) begin
        if ($urandom_range(0, 99) < insert_pct)
          push_entry(pick_priority(), TAG_W'($urandom));
        else
          pop_head();
        random_sent++;
        if (idle_on && random_sent < CALM_TAIL && $urandom_range(0, 7) == 0)
          idle_gap($urandom_range(1, 6));
      end
    end
  endtask

  initial begin
    held            = 0;
    cap_model       = CfgReset;
    errors          = 0;
    random_sent     = 0;
    n_commands      = 0;
    n_stored        = 0;
    n_served        = 0;
    n_full_rejects  = 0;
    n_negative      = 0;
    n_empty_removes = 0;
    max_held        = 0;
    n_cfg_writes    = 0;
    rst_ni         <= 1'b0;
    start          <= 1'b0;
    operation_i    <= OP_INSERT;
    priority_req_i <= '0;
    task_tag_i     <= '0;
    cfg_valid_i    <= 1'b0;
    cfg_data_i     <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_capacity();
    test_random();
    wait_drained();

    $display("summary: %0d commands, %0d stored, %0d served, %0d capacity writes",
             n_commands, n_stored, n_served, n_cfg_writes);
    $display("summary: rejects %0d full, %0d negative, %0d empty; deepest %0d; %0d errors",
             n_full_rejects, n_negative, n_empty_removes, max_held, errors);
    if (errors == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule
